FILE: design/brpg_pkg.sv
// Shared types and constants for the block RMS / peak / gate level meter.
package brpg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 15;
    localparam int GAIN_W     = 16;
    localparam int THR_W      = 15;
    localparam int GAIN_FRAC  = 12;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = 44;
    localparam int BLOCK_MAX  = 4096;
    localparam int LEN_W      = $clog2(BLOCK_MAX + 1);
    localparam int TOTAL_W    = 64;
    localparam int FULL_SCALE = (1 << MAG_W) - 1;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam int DIV_STEPS  = SUM_W;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [GAIN_W-1:0]    GAIN_RESET    = 16'd4096;
    localparam logic [THR_W-1:0]     THR_RESET     = 15'd3;

    localparam int IN_DATA_W  = 2 * SAMPLE_W;
    localparam int IN_USER_W  = 2;
    localparam int OUT_BITS   = 3 * MAG_W + 1 + TOTAL_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // One finished block as handed from the accumulator to the back end.
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [MAG_W-1:0]   peak;
        logic [LEN_W-1:0]   len;
        logic [TOTAL_W-1:0] total;
    } blk_t;

endpackage

FILE: design/brpg_front.sv
// Front end: mono mix, gain, square and block accumulation, one frame per cycle while in_ready is high.
module brpg_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [brpg_pkg::SAMPLE_W-1:0] sample_ch0,
    input  logic signed [brpg_pkg::SAMPLE_W-1:0] sample_ch1,
    input  logic [1:0]                          channel_present,
    input  logic                                last_of_block,
    input  logic [brpg_pkg::GAIN_W-1:0]         gain,
    input  logic [brpg_pkg::Q_CNT_W-1:0]        q_level,
    output logic                                push,
    output brpg_pkg::blk_t                      push_data
);

    localparam int SUM17_W = brpg_pkg::SAMPLE_W + 1;
    localparam int PROD_W  = SUM17_W + brpg_pkg::GAIN_W;
    localparam int SHR_W   = PROD_W - brpg_pkg::GAIN_FRAC;

    logic                           accept;
    logic signed [SUM17_W-1:0]      s0_ext;
    logic signed [SUM17_W-1:0]      s1_ext;
    logic signed [SUM17_W-1:0]      mix_sum;
    logic [SUM17_W-1:0]             mix_abs;
    logic [PROD_W-1:0]              prod;
    logic [SHR_W-1:0]               shifted;
    logic [brpg_pkg::MAG_W-1:0]     mag_next;

    logic                           s1_valid_reg;
    logic                           s1_last_reg;
    logic [brpg_pkg::MAG_W-1:0]     s1_mag_reg;
    logic                           s2_valid_reg;
    logic                           s2_last_reg;
    logic [brpg_pkg::MAG_W-1:0]     s2_mag_reg;
    logic [brpg_pkg::SQ_W-1:0]      s2_sq_reg;

    logic [brpg_pkg::SUM_W-1:0]     sum_reg;
    logic [brpg_pkg::MAG_W-1:0]     peak_reg;
    logic [brpg_pkg::LEN_W-1:0]     len_reg;
    logic [brpg_pkg::TOTAL_W-1:0]   total_reg;

    logic [brpg_pkg::SUM_W:0]       sum_add;
    logic [brpg_pkg::SUM_W-1:0]     sum_next;
    logic [brpg_pkg::MAG_W-1:0]     peak_next;
    logic [brpg_pkg::LEN_W-1:0]     len_next;
    logic [brpg_pkg::TOTAL_W-1:0]   total_next;
    logic [brpg_pkg::Q_CNT_W-1:0]   pending;

    // Every block end still in the pipe has a queue slot reserved for it.
    assign pending = q_level
                   + brpg_pkg::Q_CNT_W'(s1_valid_reg & s1_last_reg)
                   + brpg_pkg::Q_CNT_W'(s2_valid_reg & s2_last_reg);
    assign in_ready = (pending < brpg_pkg::Q_CNT_W'(brpg_pkg::Q_DEPTH));
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        s0_ext  = channel_present[0] ? SUM17_W'(sample_ch0) : '0;
        s1_ext  = channel_present[1] ? SUM17_W'(sample_ch1) : '0;
        mix_sum = s0_ext + s1_ext;
        mix_abs = mix_sum[SUM17_W-1] ? (~mix_sum + 1'b1) : mix_sum;
        prod    = PROD_W'(mix_abs) * PROD_W'(gain);
        // Averaging two channels adds one bit to the Q4.12 shift.
        if (channel_present == 2'b11)
        begin
            shifted = SHR_W'(prod >> (brpg_pkg::GAIN_FRAC + 1));
        end
        else
        begin
            shifted = SHR_W'(prod >> brpg_pkg::GAIN_FRAC);
        end
        if (shifted > SHR_W'(brpg_pkg::FULL_SCALE))
        begin
            mag_next = brpg_pkg::MAG_W'(brpg_pkg::FULL_SCALE);
        end
        else
        begin
            mag_next = shifted[brpg_pkg::MAG_W-1:0];
        end
    end

    always_comb
    begin
        sum_add    = {1'b0, sum_reg} + (brpg_pkg::SUM_W + 1)'(s2_sq_reg);
        sum_next   = sum_add[brpg_pkg::SUM_W] ? '1 : sum_add[brpg_pkg::SUM_W-1:0];
        peak_next  = (s2_mag_reg > peak_reg) ? s2_mag_reg : peak_reg;
        len_next   = (len_reg == brpg_pkg::LEN_W'(brpg_pkg::BLOCK_MAX)) ? len_reg
                                                                        : len_reg + 1'b1;
        total_next = total_reg + 1'b1;
    end

    assign push            = s2_valid_reg & s2_last_reg;
    assign push_data.sum   = sum_next;
    assign push_data.peak  = peak_next;
    assign push_data.len   = len_next;
    assign push_data.total = total_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_last_reg  <= accept & last_of_block;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_valid_reg & s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mag_reg <= mag_next;
        s2_mag_reg <= s1_mag_reg;
        s2_sq_reg  <= brpg_pkg::SQ_W'(s1_mag_reg) * brpg_pkg::SQ_W'(s1_mag_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            peak_reg  <= '0;
            len_reg   <= '0;
            total_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            total_reg <= total_next;
            if (s2_last_reg)
            begin
                sum_reg  <= '0;
                peak_reg <= '0;
                len_reg  <= '0;
            end
            else
            begin
                sum_reg  <= sum_next;
                peak_reg <= peak_next;
                len_reg  <= len_next;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_level < brpg_pkg::Q_CNT_W'(brpg_pkg::Q_DEPTH)))
        else $error("block end reached the queue without a free slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_last_reg |=> (len_reg != '0))
        else $error("block length did not advance after a frame");

endmodule

FILE: design/brpg_queue.sv
// Short queue of finished blocks between the front end and the back end.
module brpg_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  brpg_pkg::blk_t                push_data,
    input  logic                          pop,
    output brpg_pkg::blk_t                head,
    output logic                          nonempty,
    output logic [brpg_pkg::Q_CNT_W-1:0]  level
);

    brpg_pkg::blk_t                    mem_reg [brpg_pkg::Q_DEPTH];
    logic [brpg_pkg::Q_PTR_W-1:0]      wr_ptr_reg;
    logic [brpg_pkg::Q_PTR_W-1:0]      rd_ptr_reg;
    logic [brpg_pkg::Q_CNT_W-1:0]      count_reg;

    assign head     = mem_reg[rd_ptr_reg];
    assign nonempty = (count_reg != '0);
    assign level    = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");

endmodule

FILE: design/brpg_back.sv
// Back end: iterative mean divide and square root, gate decision and result register.
module brpg_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  brpg_pkg::blk_t                     q_data,
    output logic                               q_pop,
    input  logic [brpg_pkg::THR_W-1:0]         threshold,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [brpg_pkg::OUT_DATA_W-1:0]    m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;
    localparam int PAD_W = brpg_pkg::OUT_DATA_W - brpg_pkg::OUT_BITS;

    logic [1:0]                          state_reg;
    logic [brpg_pkg::STEP_W-1:0]         step_reg;
    logic [brpg_pkg::SUM_W-1:0]          dq_reg;
    logic [brpg_pkg::LEN_W-1:0]          div_reg;
    logic [brpg_pkg::LEN_W-1:0]          rem_reg;
    logic [brpg_pkg::SUM_W-1:0]          root_reg;
    logic [brpg_pkg::SUM_W-1:0]          bit_reg;
    logic [brpg_pkg::MAG_W-1:0]          peak_reg;
    logic [brpg_pkg::TOTAL_W-1:0]        total_reg;
    logic                                out_valid_reg;
    logic [brpg_pkg::OUT_DATA_W-1:0]     out_data_reg;

    logic [brpg_pkg::LEN_W:0]            trial;
    logic                                div_ge;
    logic [brpg_pkg::LEN_W:0]            rem_next;
    logic [brpg_pkg::SUM_W-1:0]          dq_next;
    logic [brpg_pkg::SUM_W-1:0]          root_trial;
    logic                                root_ge;
    logic                                load_out;
    logic [brpg_pkg::MAG_W-1:0]          rms;
    logic                                gate;
    logic [brpg_pkg::MAG_W-1:0]          loud;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb
    begin
        // Restoring division, one quotient bit per cycle.
        trial    = {rem_reg, dq_reg[brpg_pkg::SUM_W-1]};
        div_ge   = (trial >= {1'b0, div_reg});
        rem_next = div_ge ? (trial - {1'b0, div_reg}) : trial;
        dq_next  = {dq_reg[brpg_pkg::SUM_W-2:0], div_ge};
        // Bitwise square root, two radicand bits per cycle.
        root_trial = root_reg + bit_reg;
        root_ge    = (dq_reg >= root_trial);
        rms  = (root_reg > brpg_pkg::SUM_W'(brpg_pkg::FULL_SCALE))
             ? brpg_pkg::MAG_W'(brpg_pkg::FULL_SCALE) : root_reg[brpg_pkg::MAG_W-1:0];
        gate = (peak_reg > threshold);
        loud = gate ? rms : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (q_valid)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == brpg_pkg::STEP_W'(brpg_pkg::DIV_STEPS - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SQRT:
                begin
                    if (step_reg == brpg_pkg::STEP_W'(brpg_pkg::ROOT_STEPS - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            dq_reg    <= q_data.sum;
            div_reg   <= q_data.len;
            rem_reg   <= '0;
            peak_reg  <= q_data.peak;
            total_reg <= q_data.total;
        end
        else if (state_reg == ST_DIV)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next[brpg_pkg::LEN_W-1:0];
            // The radicand is the quotient left in dq_reg.
            root_reg <= '0;
            bit_reg  <= brpg_pkg::SUM_W'(1) << (brpg_pkg::SUM_W - 2);
        end
        else if (state_reg == ST_SQRT)
        begin
            if (root_ge)
            begin
                dq_reg   <= dq_reg - root_trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (load_out)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, total_reg, gate, loud, peak_reg, rms};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_reg != '0))
        else $error("divide started with a zero block length");

    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("result load did not raise the output or free the back end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) && (step_reg == brpg_pkg::STEP_W'(brpg_pkg::ROOT_STEPS - 1))
        |-> (bit_reg == brpg_pkg::SUM_W'(1)))
        else $error("square root ran out of step with its bit position");

endmodule

FILE: design/block_rms_peak_gate_meter_unit.sv
// Top level of the block RMS, peak and gate level meter.
//
// Input frames arrive on the s_axis channel: two 16-bit samples in tdata, the
// channel presence mask in tuser and the end of an analysis block in tlast.
// A frame is taken in every cycle while s_axis_tready is high. For each block
// the m_axis channel gives one transaction with RMS, peak, gated loudness, gate
// flag and the running frame count; frames that do not end a block give none.
// Gain and gate threshold are written through the cfg channel, which is always
// ready; write them only while no block is in flight.
// The front end mixes, scales, squares and accumulates in a three-stage pipe,
// and a block end is written into the result queue once its last frame has
// passed the s1 and s2 registers. The back end then takes a block, runs the
// bit-serial mean divide and then the bit-serial square root, and loads the
// result register; it takes no new block until that load. Blocks with enough
// frames to cover that work run at one frame per cycle; shorter ones fill the
// four-entry queue and s_axis_tready drops until the back end catches up.
// A stalled m_axis receiver holds the result register and backs up the queue
// the same way. Reset clears the accumulators, the frame count and the queue,
// and sets the gain to unity and the threshold to 3.
module block_rms_peak_gate_meter_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [brpg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [brpg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] sample_ch0, [31:16] sample_ch1
    input  logic [brpg_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [1:0] channel_present
    input  logic [brpg_pkg::IN_USER_W-1:0]       s_axis_tuser,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [14:0] rms_level, [29:15] peak_level, [44:30] loudness_level,
    // [45] gate_open, [109:46] total_sample_count, [111:110] zero
    output logic [brpg_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    logic [brpg_pkg::GAIN_W-1:0]   gain_reg;
    logic [brpg_pkg::THR_W-1:0]    thr_reg;
    logic                          push;
    brpg_pkg::blk_t                push_data;
    logic                          pop;
    brpg_pkg::blk_t                head;
    logic                          nonempty;
    logic [brpg_pkg::Q_CNT_W-1:0]  level;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= brpg_pkg::GAIN_RESET;
            thr_reg  <= brpg_pkg::THR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                brpg_pkg::REG_GAIN:
                begin
                    gain_reg <= cfg_data[brpg_pkg::GAIN_W-1:0];
                end
                brpg_pkg::REG_THRESHOLD:
                begin
                    thr_reg <= cfg_data[brpg_pkg::THR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    brpg_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .sample_ch0      (s_axis_tdata[brpg_pkg::SAMPLE_W-1:0]),
        .sample_ch1      (s_axis_tdata[2*brpg_pkg::SAMPLE_W-1:brpg_pkg::SAMPLE_W]),
        .channel_present (s_axis_tuser),
        .last_of_block   (s_axis_tlast),
        .gain            (gain_reg),
        .q_level         (level),
        .push            (push),
        .push_data       (push_data)
    );

    brpg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .nonempty  (nonempty),
        .level     (level)
    );

    brpg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (nonempty),
        .q_data    (head),
        .q_pop     (pop),
        .threshold (thr_reg),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata)
    );

endmodule
